>>> hdl/e2c_pkg.sv
// Shared types, constants and month table for the epoch-to-calendar converter.
package e2c_pkg;

	localparam int SECS_W  = 32;
	localparam int DAYS_W  = 16;
	localparam int YEAR_W  = 12;
	localparam int MON_W   = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int YLEN_W  = 9;
	localparam int CNT_W   = 4;

	localparam logic [SECS_W-1:0] DAY_SECS  = 32'd86400;
	localparam logic [SECS_W-1:0] HOUR_SECS = 32'd3600;
	localparam logic [SECS_W-1:0] MIN_SECS  = 32'd60;

	localparam logic [SECS_W-1:0] DAY_DIV_INIT  = DAY_SECS << (DAYS_W - 1);
	localparam logic [SECS_W-1:0] HOUR_DIV_INIT = HOUR_SECS << (HOUR_W - 1);
	localparam logic [SECS_W-1:0] MIN_DIV_INIT  = MIN_SECS << (MIN_W - 1);

	localparam logic [CNT_W-1:0] DAY_ITER_LAST  = CNT_W'(DAYS_W - 1);
	localparam logic [CNT_W-1:0] HOUR_ITER_LAST = CNT_W'(HOUR_W - 1);
	localparam logic [CNT_W-1:0] MIN_ITER_LAST  = CNT_W'(MIN_W - 1);

	localparam logic [YEAR_W-1:0] EPOCH_YEAR      = 12'd1970;
	localparam logic [YEAR_W-1:0] LAST_VALID_YEAR = 12'd2037;
	localparam logic [1:0]        EPOCH_MOD4      = 2'd2;
	localparam logic [6:0]        EPOCH_MOD100    = 7'd70;
	localparam logic [8:0]        EPOCH_MOD400    = 9'd370;

	localparam logic [YLEN_W-1:0] YEAR_DAYS      = 9'd365;
	localparam logic [YLEN_W-1:0] LEAP_YEAR_DAYS = 9'd366;

	localparam logic [MON_W-1:0] MON_JAN = 4'd0;
	localparam logic [MON_W-1:0] MON_FEB = 4'd1;

	typedef struct packed {
		logic init;
		logic step;
	} e2c_yr_ctl_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon);
		logic [DAY_W-1:0] len;
		unique case (mon)
			4'd0:    len = 5'd31;
			4'd1:    len = 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> hdl/e2c_alu.sv
// Shared subtract-and-compare unit used by every step of the sequencer.
module e2c_alu
	import e2c_pkg::*;
(
	input  logic [SECS_W-1:0] a,
	input  logic [SECS_W-1:0] b,
	output logic [SECS_W-1:0] diff,
	output logic              ge
);

	logic [SECS_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[SECS_W-1:0];
	assign ge   = ~full[SECS_W];

endmodule

>>> hdl/e2c_year.sv
// Year counter with running residues for the Gregorian leap-year rule.
module e2c_year
	import e2c_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  e2c_yr_ctl_t       ctl,
	output logic [YEAR_W-1:0] year,
	output logic              leap
);

	logic [YEAR_W-1:0] year_q;
	logic [1:0]        mod4_q;
	logic [6:0]        mod100_q;
	logic [8:0]        mod400_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   <= EPOCH_YEAR;
			mod4_q   <= EPOCH_MOD4;
			mod100_q <= EPOCH_MOD100;
			mod400_q <= EPOCH_MOD400;
		end else if (ctl.init) begin
			year_q   <= EPOCH_YEAR;
			mod4_q   <= EPOCH_MOD4;
			mod100_q <= EPOCH_MOD100;
			mod400_q <= EPOCH_MOD400;
		end else if (ctl.step) begin
			year_q   <= year_q + 12'd1;
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
		end
	end

	assign year = year_q;
	assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

endmodule

>>> hdl/epoch_seconds_to_calendar.sv
// Epoch seconds to calendar date and time: sequencer, datapath registers and result port.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  command  | start, busy         | epoch_seconds
//  result   | done (one cycle)    | year, month, day, hour, minute, second, date_valid
//
// A nonnegative transaction runs day division, then hour and minute division, then
// counts off the years past 1970 and then the months; done follows in the cycle
// after the last month step. A negative count returns its all-zero result in the
// cycle after start. Every step shares the single subtractor. Reset clears the
// sequencer and the done strobe. Results cannot be held off; done flags each
// for exactly one cycle.
module epoch_seconds_to_calendar
	import e2c_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [32:0] epoch_seconds,
	output logic              done,
	output logic [YEAR_W-1:0] year,
	output logic [MON_W-1:0]  month,
	output logic [DAY_W-1:0]  day,
	output logic [HOUR_W-1:0] hour,
	output logic [MIN_W-1:0]  minute,
	output logic [SEC_W-1:0]  second,
	output logic              date_valid
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DAY  = 3'd1;
	localparam logic [2:0] ST_HOUR = 3'd2;
	localparam logic [2:0] ST_MIN  = 3'd3;
	localparam logic [2:0] ST_YEAR = 3'd4;
	localparam logic [2:0] ST_MON  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SECS_W-1:0] acc_q;
	logic [SECS_W-1:0] div_q;
	logic [DAYS_W-1:0] days_q;
	logic [HOUR_W-1:0] hour_q;
	logic [MIN_W-1:0]  minute_q;
	logic [MON_W-1:0]  mon_q;

	logic              done_q;
	logic [YEAR_W-1:0] year_q;
	logic [MON_W-1:0]  month_q;
	logic [DAY_W-1:0]  day_q;
	logic [HOUR_W-1:0] hour_out_q;
	logic [MIN_W-1:0]  minute_out_q;
	logic [SEC_W-1:0]  second_q;
	logic              date_valid_q;

	logic              accept;
	logic [SECS_W-1:0] alu_a;
	logic [SECS_W-1:0] alu_b;
	logic [SECS_W-1:0] alu_diff;
	logic              alu_ge;
	logic [DAY_W-1:0]  mlen;
	e2c_yr_ctl_t       yr_ctl;
	logic [YEAR_W-1:0] cur_year;
	logic              cur_leap;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		mlen = month_days(mon_q) + {4'd0, (mon_q == MON_FEB) && cur_leap};
		unique case (state_q)
			ST_DAY, ST_HOUR, ST_MIN: begin
				alu_a = acc_q;
				alu_b = div_q;
			end
			ST_YEAR: begin
				alu_a = {{(SECS_W-DAYS_W){1'b0}}, days_q};
				alu_b = {{(SECS_W-YLEN_W){1'b0}}, cur_leap ? LEAP_YEAR_DAYS : YEAR_DAYS};
			end
			ST_MON: begin
				alu_a = {{(SECS_W-DAYS_W){1'b0}}, days_q};
				alu_b = {{(SECS_W-DAY_W){1'b0}}, mlen};
			end
			default: begin
				alu_a = acc_q;
				alu_b = div_q;
			end
		endcase
		yr_ctl.init = accept && !epoch_seconds[32];
		yr_ctl.step = (state_q == ST_YEAR) && alu_ge;
	end

	e2c_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	e2c_year u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (yr_ctl),
		.year   (cur_year),
		.leap   (cur_leap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (epoch_seconds[32]) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_DAY;
						end
					end
				end
				ST_DAY: begin
					if (cnt_q == '0) begin
						state_q <= ST_HOUR;
					end
				end
				ST_HOUR: begin
					if (cnt_q == '0) begin
						state_q <= ST_MIN;
					end
				end
				ST_MIN: begin
					if (cnt_q == '0) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (!alu_ge) begin
						state_q <= ST_MON;
					end
				end
				ST_MON: begin
					if (!alu_ge) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					acc_q  <= epoch_seconds[SECS_W-1:0];
					div_q  <= DAY_DIV_INIT;
					cnt_q  <= DAY_ITER_LAST;
					days_q <= '0;
					if (epoch_seconds[32]) begin
						year_q       <= '0;
						month_q      <= '0;
						day_q        <= '0;
						hour_out_q   <= '0;
						minute_out_q <= '0;
						second_q     <= '0;
						date_valid_q <= 1'b0;
					end
				end
			end
			ST_DAY: begin
				if (alu_ge) begin
					acc_q <= alu_diff;
				end
				days_q <= {days_q[DAYS_W-2:0], alu_ge};
				if (cnt_q == '0) begin
					div_q <= HOUR_DIV_INIT;
					cnt_q <= HOUR_ITER_LAST;
				end else begin
					div_q <= div_q >> 1;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_HOUR: begin
				if (alu_ge) begin
					acc_q <= alu_diff;
				end
				hour_q <= {hour_q[HOUR_W-2:0], alu_ge};
				if (cnt_q == '0) begin
					div_q <= MIN_DIV_INIT;
					cnt_q <= MIN_ITER_LAST;
				end else begin
					div_q <= div_q >> 1;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_MIN: begin
				if (alu_ge) begin
					acc_q <= alu_diff;
				end
				minute_q <= {minute_q[MIN_W-2:0], alu_ge};
				div_q    <= div_q >> 1;
				cnt_q    <= cnt_q - CNT_W'(1);
			end
			ST_YEAR: begin
				if (alu_ge) begin
					days_q <= alu_diff[DAYS_W-1:0];
				end else begin
					mon_q <= MON_JAN;
				end
			end
			ST_MON: begin
				if (alu_ge) begin
					days_q <= alu_diff[DAYS_W-1:0];
					mon_q  <= mon_q + MON_W'(1);
				end else begin
					year_q       <= cur_year;
					month_q      <= mon_q + MON_W'(1);
					day_q        <= days_q[DAY_W-1:0] + DAY_W'(1);
					hour_out_q   <= hour_q;
					minute_out_q <= minute_q;
					second_q     <= acc_q[SEC_W-1:0];
					date_valid_q <= (cur_year <= LAST_VALID_YEAR);
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign done       = done_q;
	assign year       = year_q;
	assign month      = month_q;
	assign day        = day_q;
	assign hour       = hour_out_q;
	assign minute     = minute_out_q;
	assign second     = second_q;
	assign date_valid = date_valid_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still in work");

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && epoch_seconds[32]) |=> (done && !date_valid && year == '0
			&& month == '0 && day == '0))
		else $error("negative count did not give an all-zero result");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && date_valid) |-> (year >= EPOCH_YEAR && year <= LAST_VALID_YEAR
			&& month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && hour <= 5'd23
			&& minute <= 6'd59 && second <= 6'd59))
		else $error("valid result out of calendar range");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without a start");

endmodule

>>> bench/epoch_seconds_to_calendar_test.sv
// Self-checking bench for the epoch-to-calendar converter: directed boundary stamps, then random stamps.
module epoch_seconds_to_calendar_test;
	import e2c_pkg::*;

	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int DRAIN_CYCLES     = 200;
	localparam int RANDOM_PER_PHASE = 445;
	localparam int DAY_SECONDS      = 86400;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
		logic              date_valid;
	} calendar_t;

	class date_scoreboard;
		calendar_t   pending_dates[$];
		int          errors;
		int unsigned month_len[12];

		function new();
			errors = 0;
			month_len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		endfunction

		function bit is_leap(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function calendar_t to_calendar(logic [32:0] raw);
			calendar_t   c;
			int unsigned secs, days, rem, y, m, ylen, mlen;
			c = '0;
			if (raw[32])
				return c;
			secs = raw[31:0];
			days = secs / DAY_SECONDS;
			rem  = secs % DAY_SECONDS;
			y = EPOCH_YEAR;
			forever begin
				ylen = is_leap(y) ? 366 : 365;
				if (days < ylen)
					break;
				days -= ylen;
				y++;
			end
			m = 0;
			while (m < 12) begin
				mlen = month_len[m] + ((m == MON_FEB && is_leap(y)) ? 1 : 0);
				if (days < mlen)
					break;
				days -= mlen;
				m++;
			end
			c.year       = YEAR_W'(y);
			c.month      = MON_W'(m + 1);
			c.day        = DAY_W'(days + 1);
			c.hour       = HOUR_W'(rem / 3600);
			c.minute     = MIN_W'((rem % 3600) / 60);
			c.second     = SEC_W'(rem % 60);
			c.date_valid = (y <= LAST_VALID_YEAR);
			return c;
		endfunction

		function void note_stamp(logic [32:0] raw);
			pending_dates.push_back(to_calendar(raw));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_date(calendar_t got);
			calendar_t want;
			if (pending_dates.size() == 0) begin
				errors++;
				$display("%0t: result expected none actual %0d-%0d-%0d %0d:%0d:%0d valid %0d",
					$time, got.year, got.month, got.day, got.hour, got.minute, got.second,
					got.date_valid);
				return;
			end
			want = pending_dates.pop_front();
			compare_field("year", want.year, got.year);
			compare_field("month", want.month, got.month);
			compare_field("day", want.day, got.day);
			compare_field("hour", want.hour, got.hour);
			compare_field("minute", want.minute, got.minute);
			compare_field("second", want.second, got.second);
			compare_field("date_valid", want.date_valid, got.date_valid);
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [32:0] epoch_seconds = '0;
	logic               busy;
	logic               done;
	logic [YEAR_W-1:0]  year;
	logic [MON_W-1:0]   month;
	logic [DAY_W-1:0]   day;
	logic [HOUR_W-1:0]  hour;
	logic [MIN_W-1:0]   minute;
	logic [SEC_W-1:0]   second;
	logic               date_valid;

	date_scoreboard     sb = new();
	int                 idle_pct = 0;
	int                 idle_cycles = 0;
	logic signed [32:0] boundary_stamps[23];
	int                 phase_idle[4] = '{0, 82, 0, 15};

	epoch_seconds_to_calendar dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.epoch_seconds(epoch_seconds),
		.done         (done),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.date_valid   (date_valid)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_date({year, month, day, hour, minute, second, date_valid});
			if (start && !busy)
				sb.note_stamp(epoch_seconds);
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("epoch_seconds_to_calendar regression: fail");
				$finish;
			end
		end
	end

	task automatic send_stamp(input logic signed [32:0] stamp);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		epoch_seconds <= stamp;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (sb.pending_dates.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [32:0] random_stamp();
		int unsigned pick, days, sod;
		pick = $urandom_range(99);
		if (pick < 12)
			return {1'($urandom_range(1)), 32'($urandom())};
		if (pick < 55)
			return {1'b0, 32'($urandom_range(2145916799, 0))};
		if (pick < 70)
			return {1'b0, 32'($urandom())};
		days = $urandom_range(49709, 0);
		case ($urandom_range(2))
			0: sod = 0;
			1: sod = DAY_SECONDS - 1;
			default: sod = $urandom_range(DAY_SECONDS - 1, 0);
		endcase
		return {1'b0, 32'(days * DAY_SECONDS + sod)};
	endfunction

	initial begin
		boundary_stamps = '{
			33'd0, 33'd1, 33'd59, 33'd60, 33'd3599, 33'd3600, 33'd86399, 33'd86400,
			33'd31535999, 33'd31536000,
			33'd68255999, 33'd68256000,
			33'd951825600,
			33'd4107542399, 33'd4107542400,
			33'd2145916799, 33'd2145916800,
			33'h0_7FFF_FFFF, 33'h0_8000_0000, 33'h0_FFFF_FFFF,
			33'h1_FFFF_FFFF, 33'h1_8000_0000, 33'h1_0000_0000
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (boundary_stamps[i])
			send_stamp(boundary_stamps[i]);
		start <= 1'b0;
		wait_drained();

		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			repeat (RANDOM_PER_PHASE)
				send_stamp(random_stamp());
			start <= 1'b0;
			// hold off until every result of the phase is back
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_dates.size() == 0)
			$display("epoch_seconds_to_calendar regression: pass");
		else
			$display("epoch_seconds_to_calendar regression: fail");
		$finish;
	end

endmodule

>>> sim.f
hdl/e2c_pkg.sv
hdl/e2c_alu.sv
hdl/e2c_year.sv
hdl/epoch_seconds_to_calendar.sv
bench/epoch_seconds_to_calendar_test.sv
